FILE: design/assert_macros.svh
// assertion helpers used by the checker file msg_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every edge outside reset
`define MSG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// property that holds on every edge, reset included
`define MSG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed: label");

`endif

FILE: design/msg_pkg.sv
// ---------------------------------------------------------------------------
// msg_pkg
// Shared types and constants of the color gradient pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package msg_pkg;

   localparam int FRAC_BITS  = 12;
   localparam int POS_W      = 13;
   localparam int WORD_W     = 45;
   localparam int COLOR_W    = 32;
   localparam int LEVEL_W    = 16;
   localparam int COUNT_W    = 3;
   localparam int INDEX_W    = 3;
   localparam int SUM_W      = 21;

   // register indexes
   localparam logic [INDEX_W-1:0] REG_STOP_COUNT = 3'd0;
   localparam logic [INDEX_W-1:0] REG_STOP_WORD0 = 3'd1;

   // unit value in level scale
   localparam logic [POS_W-1:0] ONE_POS = 13'd4096;

   // opaque black, packed {alpha, blue, green, red}
   localparam logic [COLOR_W-1:0] BLACK = 32'hFF00_0000;

   // one item in flight through search and divider
   typedef struct packed {
      logic                   valid;
      logic                   direct;
      logic [COLOR_W-1:0]     color;
      logic [COLOR_W-1:0]     lo_color;
      logic [COLOR_W-1:0]     hi_color;
      logic [POS_W-1:0]       rem;
      logic [POS_W-1:0]       den;
      logic [FRAC_BITS-1:0]   quo;
   } msg_work_type;

endpackage

`default_nettype wire

FILE: design/multi_stop_color_gradient_unit.sv
// ---------------------------------------------------------------------------
// multi_stop_color_gradient_unit
// Maps a signed 4.12 fixed-point level to an RGBA color over up to six stops.
// ---------------------------------------------------------------------------
// A new level word can be taken on every clock while the output is not
// stalled; each word passes fifteen register stages to the result port:
// one search stage that finds the bracketing stops, twelve divider stages
// that each resolve one fraction bit, one multiply stage and one output
// register. The whole pipeline holds while a result word waits on
// rsp_ready, so req_ready equals "output empty or being taken". Stops are
// written through the csr port (index 0 stop count, 1 to 6 stop words) and
// should only change while no word is in flight.
`default_nettype none

module multi_stop_color_gradient_unit #(
   parameter int MAX_STOPS = 6
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  signed [15:0]             req_level,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [7:0]                     rsp_red,
   output logic [7:0]                     rsp_green,
   output logic [7:0]                     rsp_blue,
   output logic [7:0]                     rsp_alpha,
   input  wire                            csr_write,
   input  wire  [msg_pkg::INDEX_W-1:0]    csr_index,
   input  wire  [msg_pkg::WORD_W-1:0]     csr_wdata
);

   logic [msg_pkg::COUNT_W-1:0]  stop_count_ff;
   logic [msg_pkg::WORD_W-1:0]   stop_word_ff [MAX_STOPS];
   logic                         advance;

   msg_pkg::msg_work_type        stage [msg_pkg::FRAC_BITS+1];

   // stop registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= msg_pkg::COUNT_W'(2);
         for (int i = 0; i < MAX_STOPS; i++) begin
            stop_word_ff[i] <= '0;
         end
         stop_word_ff[0] <= msg_pkg::WORD_W'(msg_pkg::BLACK) << msg_pkg::POS_W;
         stop_word_ff[1] <= (msg_pkg::WORD_W'(msg_pkg::BLACK) << msg_pkg::POS_W) |
                            msg_pkg::WORD_W'(msg_pkg::ONE_POS);
      end else if (csr_write) begin
         if (csr_index == msg_pkg::REG_STOP_COUNT) begin
            stop_count_ff <= csr_wdata[msg_pkg::COUNT_W-1:0];
         end
         for (int i = 0; i < MAX_STOPS; i++) begin
            if (csr_index == msg_pkg::REG_STOP_WORD0 + msg_pkg::INDEX_W'(i)) begin
               stop_word_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // whole pipeline moves unless the output word is stalled
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   msg_search #(.MAX_STOPS(MAX_STOPS)) u_search (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .level      (req_level),
      .stop_count (stop_count_ff),
      .stop_word  (stop_word_ff),
      .work_out   (stage[0])
   );

   // one fraction bit per stage
   for (genvar s = 0; s < msg_pkg::FRAC_BITS; s++) begin : g_div
      msg_div_stage u_div (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .work_inp (stage[s]),
         .work_out (stage[s+1])
      );
   end

   msg_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .work_inp  (stage[msg_pkg::FRAC_BITS]),
      .out_valid (rsp_valid),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue),
      .alpha     (rsp_alpha)
   );

endmodule

`default_nettype wire

FILE: design/msg_search.sv
// ---------------------------------------------------------------------------
// msg_search
// Entry stage: finds the bracketing stops of a level and registers them.
// ---------------------------------------------------------------------------
`default_nettype none

module msg_search #(
   parameter int MAX_STOPS = 6
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   advance,
   input  wire                                   in_valid,
   input  wire  [msg_pkg::LEVEL_W-1:0]           level,
   input  wire  [msg_pkg::COUNT_W-1:0]           stop_count,
   input  wire  [msg_pkg::WORD_W-1:0]            stop_word [MAX_STOPS],
   output msg_pkg::msg_work_type                 work_out
);

   localparam int IW = (MAX_STOPS > 2) ? $clog2(MAX_STOPS) : 1;

   msg_pkg::msg_work_type work_ff, work_in;

   logic [msg_pkg::COUNT_W-1:0]  n;
   logic [msg_pkg::POS_W-1:0]    lvl;
   logic [msg_pkg::POS_W-1:0]    pos;
   logic [msg_pkg::POS_W-1:0]    pos_lo, pos_hi;
   logic                         out_range, lo_found, hi_found, eq_found, done;
   logic [IW-1:0]                lo_idx, hi_idx, eq_idx, last_idx;

   // clamp the stop count
   always_comb begin
      if (stop_count < msg_pkg::COUNT_W'(2)) begin
         n = msg_pkg::COUNT_W'(2);
      end else if (stop_count > msg_pkg::COUNT_W'(MAX_STOPS)) begin
         n = msg_pkg::COUNT_W'(MAX_STOPS);
      end else begin
         n = stop_count;
      end
   end

   // scan stops in index order
   always_comb begin
      out_range = level[msg_pkg::LEVEL_W-1] ||
                  (level[msg_pkg::LEVEL_W-2:0] > (msg_pkg::LEVEL_W-1)'(msg_pkg::ONE_POS));
      lvl      = level[msg_pkg::POS_W-1:0];
      lo_found = 1'b0;
      hi_found = 1'b0;
      eq_found = 1'b0;
      done     = 1'b0;
      lo_idx   = '0;
      hi_idx   = '0;
      eq_idx   = '0;
      pos      = '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
         pos = stop_word[i][msg_pkg::POS_W-1:0];
         if ((msg_pkg::COUNT_W'(i) < n) && !done) begin
            if (lvl > pos) begin
               lo_found = 1'b1;
               lo_idx   = IW'(i);
            end else if (lvl < pos) begin
               hi_found = 1'b1;
               hi_idx   = IW'(i);
               done     = 1'b1;
            end else begin
               eq_found = 1'b1;
               eq_idx   = IW'(i);
               done     = 1'b1;
            end
         end
      end
      last_idx = IW'(n - msg_pkg::COUNT_W'(1));
   end

   // build the stage word
   always_comb begin
      pos_lo           = stop_word[lo_idx][msg_pkg::POS_W-1:0];
      pos_hi           = stop_word[hi_idx][msg_pkg::POS_W-1:0];
      work_in.valid    = in_valid;
      work_in.direct   = out_range || eq_found || !lo_found || !hi_found;
      work_in.lo_color = stop_word[lo_idx][msg_pkg::WORD_W-1:msg_pkg::POS_W];
      work_in.hi_color = stop_word[hi_idx][msg_pkg::WORD_W-1:msg_pkg::POS_W];
      work_in.rem      = lvl - pos_lo;
      work_in.den      = pos_hi - pos_lo;
      work_in.quo      = '0;
      if (out_range) begin
         work_in.color = msg_pkg::BLACK;
      end else if (eq_found) begin
         work_in.color = stop_word[eq_idx][msg_pkg::WORD_W-1:msg_pkg::POS_W];
      end else if (!lo_found) begin
         work_in.color = stop_word[0][msg_pkg::WORD_W-1:msg_pkg::POS_W];
      end else begin
         work_in.color = stop_word[last_idx][msg_pkg::WORD_W-1:msg_pkg::POS_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff.valid <= 1'b0;
      end else if (advance) begin
         work_ff <= work_in;
      end
   end

   assign work_out = work_ff;

endmodule

`default_nettype wire

FILE: design/msg_div_stage.sv
// ---------------------------------------------------------------------------
// msg_div_stage
// One restoring division step: produces one fraction bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module msg_div_stage (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  msg_pkg::msg_work_type work_inp,
   output msg_pkg::msg_work_type work_out
);

   msg_pkg::msg_work_type work_ff, work_in;

   logic [msg_pkg::POS_W:0] shifted;
   logic                    bit_q;

   // shift remainder, trial subtract
   always_comb begin
      shifted  = {work_inp.rem, 1'b0};
      bit_q    = (shifted >= {1'b0, work_inp.den});
      work_in  = work_inp;
      if (bit_q) begin
         work_in.rem = msg_pkg::POS_W'(shifted - {1'b0, work_inp.den});
      end else begin
         work_in.rem = shifted[msg_pkg::POS_W-1:0];
      end
      work_in.quo = {work_inp.quo[msg_pkg::FRAC_BITS-2:0], bit_q};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff.valid <= 1'b0;
      end else if (advance) begin
         work_ff <= work_in;
      end
   end

   assign work_out = work_ff;

endmodule

`default_nettype wire

FILE: design/msg_blend.sv
// ---------------------------------------------------------------------------
// msg_blend
// Weights the two stop colors by the fraction, or passes the direct color,
// and drives the result word.
`default_nettype none

module msg_blend (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  msg_pkg::msg_work_type work_inp,
   output logic                  out_valid,
   output logic [7:0]            red,
   output logic [7:0]            green,
   output logic [7:0]            blue,
   output logic [7:0]            alpha
);

   logic                          mul_valid_ff;
   logic                          mul_direct_ff;
   logic [msg_pkg::COLOR_W-1:0]   mul_color_ff;
   logic [msg_pkg::SUM_W-1:0]     sum_ff [4];
   logic [msg_pkg::SUM_W-1:0]     sum_in [4];
   logic [msg_pkg::POS_W-1:0]     weight_lo;

   logic                          out_valid_ff;
   logic [msg_pkg::COLOR_W-1:0]   out_color_ff, out_color_in;

   // per channel weighted sum
   always_comb begin
      weight_lo = msg_pkg::ONE_POS - msg_pkg::POS_W'(work_inp.quo);
      for (int c = 0; c < 4; c++) begin
         sum_in[c] = msg_pkg::SUM_W'(work_inp.hi_color[8*c +: 8]) *
                     msg_pkg::SUM_W'(work_inp.quo) +
                     msg_pkg::SUM_W'(work_inp.lo_color[8*c +: 8]) *
                     msg_pkg::SUM_W'(weight_lo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= work_inp.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_direct_ff <= work_inp.direct;
         mul_color_ff  <= work_inp.color;
         for (int c = 0; c < 4; c++) begin
            sum_ff[c] <= sum_in[c];
         end
      end
   end

   // scale down and pick the direct color
   always_comb begin
      if (mul_direct_ff) begin
         out_color_in = mul_color_ff;
      end else begin
         for (int c = 0; c < 4; c++) begin
            out_color_in[8*c +: 8] = sum_ff[c][msg_pkg::FRAC_BITS +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_color_ff <= out_color_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign red       = out_color_ff[7:0];
   assign green     = out_color_ff[15:8];
   assign blue      = out_color_ff[23:16];
   assign alpha     = out_color_ff[31:24];

endmodule

`default_nettype wire

FILE: design/msg_checker.sv
// ---------------------------------------------------------------------------
// msg_checker
// Port level checks of the gradient unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msg_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_ready,
   input  wire        rsp_valid,
   input  wire        rsp_ready,
   input  wire [7:0]  rsp_red,
   input  wire [7:0]  rsp_green,
   input  wire [7:0]  rsp_blue,
   input  wire [7:0]  rsp_alpha
);

   // no result word right after reset
   `MSG_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // input side opens whenever the output can move
   `MSG_ASSERT(a_ready_follows_out, clock, reset, req_ready == (!rsp_valid || rsp_ready))

   // stalled result word holds its color
   `MSG_ASSERT(a_hold_color, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable({rsp_red, rsp_green, rsp_blue, rsp_alpha})))

endmodule

bind multi_stop_color_gradient_unit msg_checker u_msg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue),
   .rsp_alpha (rsp_alpha)
);

`default_nettype wire
